### design/rpa_pkg.sv
// ============================================================================
// rpa_pkg
// Shared types, constants and the sine coefficient table for the principal
// axis point rotator.
// ============================================================================
package rpa_pkg;

    // coordinate format: signed q16.16
    localparam int COORD_W = 32;

    // coefficient format: sign, one integer bit, COEF_FRAC_BITS fraction bits
    localparam int COEF_FRAC_BITS = 15;
    localparam int COEF_MAG_W     = COEF_FRAC_BITS + 1;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;

    // product and rounded term widths
    localparam int PROD_W = COORD_W + COEF_W;
    localparam int TERM_W = PROD_W - COEF_FRAC_BITS;
    localparam int SUM_W  = TERM_W + 1;

    // table build constants
    localparam int          TABLE_FRAC_BITS   = 30;
    localparam logic [63:0] PI_Q60            = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_PER_HALF_TURN = 64'd180;
    localparam logic [63:0] DEG_STEP_Q60      = PI_Q60 / DEG_PER_HALF_TURN;
    localparam int          TAB_LAST          = 90;
    localparam int          TAB_IDX_W         = 7;

    // angle reduction: quotient by 360 through a reciprocal multiply
    localparam int             ANGLE_W     = 16;
    localparam int             REM_W       = 9;
    localparam int             QUO_W       = 8;
    localparam logic [16:0]    MOD_RECIP   = 17'd46604;
    localparam int             MOD_SHIFT   = 24;
    localparam logic [16:0]    FULL_TURN   = 17'd360;
    localparam logic [REM_W-1:0] DEG_90    = 9'd90;
    localparam logic [REM_W-1:0] DEG_180   = 9'd180;
    localparam logic [REM_W-1:0] DEG_270   = 9'd270;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 1'b1;
    localparam int CFG_DATA_W = 16;

    // axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef logic        [COEF_MAG_W-1:0] t_coef_mag;
    typedef t_coef_mag   [TAB_LAST:0]     t_sine_tab;
    typedef logic signed [COEF_W-1:0]     t_coef;
    typedef logic signed [COORD_W-1:0]    t_coord;
    typedef logic signed [TERM_W-1:0]     t_term;
    typedef logic signed [SUM_W-1:0]      t_sum;

    // unsigned long division by shift and subtract, for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(k deg) for k = 0..90, integer taylor series in q31, rounded to q30
    // and then to COEF_FRAC_BITS; evaluated at elaboration only
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab          tab;
        logic [63:0]        step;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        d;
        logic [63:0]        q30;
        logic [63:0]        m;
        logic signed [63:0] acc;
        int                 sh;
        sh   = TABLE_FRAC_BITS - COEF_FRAC_BITS;
        step = DEG_STEP_Q60;
        for (int k = 0; k <= TAB_LAST; k++) begin
            x   = (step * 64'(k) + (64'd1 << 28)) >> 29;
            x2  = (x * x + (64'd1 << 30)) >> 31;
            acc = signed'(x);
            t   = x;
            for (int n = 1; n <= 13; n++) begin
                d = 64'(2 * n) * 64'(2 * n + 1);
                t = (t * x2 + (64'd1 << 30)) >> 31;
                t = udiv64(t + (d >> 1), d);
                if ((n % 2) == 1) begin
                    acc = acc - signed'(t);
                end else begin
                    acc = acc + signed'(t);
                end
            end
            if (acc < 0) begin
                acc = 64'sd0;
            end
            q30 = (unsigned'(acc) + 64'd1) >> 1;
            if (q30 > (64'd1 << TABLE_FRAC_BITS)) begin
                q30 = 64'd1 << TABLE_FRAC_BITS;
            end
            m = q30;
            if (sh > 0) begin
                m = (q30 + (64'd1 << (sh - 1))) >> sh;
            end
            tab[k] = m[COEF_MAG_W-1:0];
        end
        tab[TAB_LAST] = COEF_MAG_W'(64'd1 << COEF_FRAC_BITS);
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();
    localparam t_coef     COEF_ONE = t_coef'({1'b0, SINE_TAB[TAB_LAST]});

endpackage

### design/rotate_point_about_axis_top.sv
// ============================================================================
// rotate_point_about_axis_top
// Rotates a stream of q16.16 points about the x, y or z axis by a
// configured whole-degree angle, with rounded products and saturated sums.
// ============================================================================
// usage
//   input channel: an item (x, y, z, last) is taken at a rising edge where
//   start is high and busy is low. busy is high in reset and clears once
//   reset is released, so from then on a new item can be taken every cycle.
//   result channel: o_valid is high for exactly one cycle with the rotated
//   point, the saturated flag and the last marker; the receiver cannot
//   stall, so nothing is held back.
//   result path: an item taken at an edge passes three registers (input,
//   rounded products, saturated sums) before its result shows on o_valid.
//   throughput: one item per cycle, set by the fully pipelined datapath of
//   four parallel 32 x 17 multipliers.
//   configuration: write enable, index (0 axis, 1 angle) and data. the angle
//   is reduced modulo 360 on the write itself; cosine and sine are
//   registered in the following cycle, so an item may start the cycle after
//   a write.
//   reset: synchronous active low; axis x, angle 0, pipeline emptied.
// ============================================================================
module rotate_point_about_axis_top
    import rpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    i_x_in,
    input  logic [COORD_W-1:0]    i_y_in,
    input  logic [COORD_W-1:0]    i_z_in,
    input  logic                  i_last_in,
    // result items
    output logic                  o_valid,
    output logic [COORD_W-1:0]    o_x_out,
    output logic [COORD_W-1:0]    o_y_out,
    output logic [COORD_W-1:0]    o_z_out,
    output logic                  o_saturated,
    output logic                  o_last_out
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_axis            r_axis;
    logic [REM_W-1:0] r_rem;     // angle modulo 360
    logic [REM_W-1:0] n_rem;
    logic             r_busy;

    // angle mod 360: quotient by reciprocal (exact for 16-bit angles)
    logic [32:0]   mod_prod;
    logic [QUO_W-1:0] mod_quo;
    logic [16:0]   mod_rem;

    always_comb begin
        mod_prod = {17'd0, i_cfg_data[ANGLE_W-1:0]} * {16'd0, MOD_RECIP};
        mod_quo  = mod_prod[MOD_SHIFT +: QUO_W];
        mod_rem  = {1'b0, i_cfg_data[ANGLE_W-1:0]} - {9'd0, mod_quo} * FULL_TURN;
        n_rem    = mod_rem[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_X;
            r_rem  <= '0;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AXIS:  r_axis <= t_axis'(i_cfg_data[1:0]);
                    CFG_ANGLE: r_rem  <= n_rem;
                    default:   r_rem  <= r_rem;
                endcase
            end
        end
    end

    assign busy = r_busy;

    // ------------------------------------------------------------------
    // cosine and sine from the quarter-wave table
    // ------------------------------------------------------------------
    logic [1:0]           quad;
    logic [REM_W-1:0]     quad_base;
    logic [REM_W-1:0]     off_full;
    logic [TAB_IDX_W-1:0] idx_r;
    logic [TAB_IDX_W-1:0] idx_c;
    t_coef                mag_r;
    t_coef                mag_c;
    t_coef                n_cos;
    t_coef                n_sin;
    t_coef                r_cos;
    t_coef                r_sin;
    t_coef                r_nsin;

    always_comb begin
        if (r_rem >= DEG_270) begin
            quad      = 2'd3;
            quad_base = DEG_270;
        end else if (r_rem >= DEG_180) begin
            quad      = 2'd2;
            quad_base = DEG_180;
        end else if (r_rem >= DEG_90) begin
            quad      = 2'd1;
            quad_base = DEG_90;
        end else begin
            quad      = 2'd0;
            quad_base = '0;
        end
        off_full = r_rem - quad_base;
        idx_r    = off_full[TAB_IDX_W-1:0];
        idx_c    = TAB_IDX_W'(TAB_LAST) - idx_r;
        mag_r    = t_coef'({1'b0, SINE_TAB[idx_r]});
        mag_c    = t_coef'({1'b0, SINE_TAB[idx_c]});
        case (quad)
            2'd0: begin
                n_sin = mag_r;
                n_cos = mag_c;
            end
            2'd1: begin
                n_sin = mag_c;
                n_cos = -mag_r;
            end
            2'd2: begin
                n_sin = -mag_r;
                n_cos = -mag_c;
            end
            default: begin
                n_sin = -mag_c;
                n_cos = mag_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos  <= COEF_ONE;
            r_sin  <= '0;
            r_nsin <= '0;
        end else begin
            r_cos  <= n_cos;
            r_sin  <= n_sin;
            r_nsin <= -n_sin;
        end
    end

    // ------------------------------------------------------------------
    // stage a: input register
    // ------------------------------------------------------------------
    logic   r_vld_a;
    t_coord r_x_a;
    t_coord r_y_a;
    t_coord r_z_a;
    logic   r_last_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_x_a    <= i_x_in;
            r_y_a    <= i_y_in;
            r_z_a    <= i_z_in;
            r_last_a <= i_last_in;
        end
    end

    // ------------------------------------------------------------------
    // stage b: rounded products
    // the two rotated coordinates are a = c*p - s*q and b = s*p + c*q with
    // (p, q) = (y, z), (z, x) or (x, y) for the x, y and z axis
    // ------------------------------------------------------------------
    t_coord p_sel;
    t_coord q_sel;

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                p_sel = r_y_a;
                q_sel = r_z_a;
            end
            AXIS_Y: begin
                p_sel = r_z_a;
                q_sel = r_x_a;
            end
            default: begin
                p_sel = r_x_a;
                q_sel = r_y_a;
            end
        endcase
    end

    // product rounded to nearest, ties toward plus infinity
    function automatic t_term round_term(input t_coord coord, input t_coef coef);
        logic signed [PROD_W-1:0] prod;
        prod = PROD_W'(coord) * PROD_W'(coef);
        prod = prod + (PROD_W'(1) <<< (COEF_FRAC_BITS - 1));
        return t_term'(prod >>> COEF_FRAC_BITS);
    endfunction

    logic   r_vld_b;
    t_term  r_pc_b;
    t_term  r_qns_b;
    t_term  r_ps_b;
    t_term  r_qc_b;
    t_coord r_x_b;
    t_coord r_y_b;
    t_coord r_z_b;
    logic   r_last_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc_b   <= round_term(p_sel, r_cos);
        r_qns_b  <= round_term(q_sel, r_nsin);
        r_ps_b   <= round_term(p_sel, r_sin);
        r_qc_b   <= round_term(q_sel, r_cos);
        r_x_b    <= r_x_a;
        r_y_b    <= r_y_a;
        r_z_b    <= r_z_a;
        r_last_b <= r_last_a;
    end

    // ------------------------------------------------------------------
    // stage c: sums, saturation and output register
    // ------------------------------------------------------------------
    function automatic t_coord sat32(input t_sum v);
        if (v > t_sum'({1'b0, {(COORD_W-1){1'b1}}})) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < -t_sum'({1'b1, {(COORD_W-1){1'b0}}})) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    function automatic logic is_clamped(input t_sum v);
        return v[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){v[SUM_W-1]}};
    endfunction

    t_sum   sum_a;
    t_sum   sum_b;
    t_coord sat_a;
    t_coord sat_b;
    logic   sat_any;
    t_coord n_x;
    t_coord n_y;
    t_coord n_z;
    logic   n_sat;

    always_comb begin
        sum_a   = SUM_W'(r_pc_b) + SUM_W'(r_qns_b);
        sum_b   = SUM_W'(r_ps_b) + SUM_W'(r_qc_b);
        sat_a   = sat32(sum_a);
        sat_b   = sat32(sum_b);
        sat_any = is_clamped(sum_a) || is_clamped(sum_b);
        n_x     = r_x_b;
        n_y     = r_y_b;
        n_z     = r_z_b;
        n_sat   = sat_any;
        case (r_axis)
            AXIS_X: begin
                n_y = sat_a;
                n_z = sat_b;
            end
            AXIS_Y: begin
                n_z = sat_a;
                n_x = sat_b;
            end
            AXIS_Z: begin
                n_x = sat_a;
                n_y = sat_b;
            end
            default: begin
                // unused axis code: point passes unchanged
                n_sat = 1'b0;
            end
        endcase
    end

    logic   r_vld_c;
    t_coord r_x_c;
    t_coord r_y_c;
    t_coord r_z_c;
    logic   r_sat_c;
    logic   r_last_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_c    <= n_x;
        r_y_c    <= n_y;
        r_z_c    <= n_z;
        r_sat_c  <= n_sat;
        r_last_c <= r_last_b;
    end

    assign o_valid     = r_vld_c;
    assign o_x_out     = r_x_c;
    assign o_y_out     = r_y_c;
    assign o_z_out     = r_z_c;
    assign o_saturated = r_sat_c;
    assign o_last_out  = r_last_c;

endmodule

### dv/tb_rotate_point_about_axis_top.sv
// ============================================================================
// tb_rotate_point_about_axis_top
// Self-checking bench for the principal axis point rotator. A scoreboard
// predicts every rotated point from the programmed axis and angle and
// compares each result strobe with the oldest prediction. The stimulus is a
// directed pass over the extremes, the exact quarter turns, rounding ties,
// saturation and the unused axis code. After that come about 2000 random
// points over three sender idle profiles, reprogrammed every 100 points.
// ============================================================================

typedef struct packed {
    rpa_pkg::t_coord x;
    rpa_pkg::t_coord y;
    rpa_pkg::t_coord z;
    logic            last;
} point_item_t;

typedef struct packed {
    rpa_pkg::t_coord x;
    rpa_pkg::t_coord y;
    rpa_pkg::t_coord z;
    logic            saturated;
    logic            last;
} rotated_point_t;

class rotation_scoreboard;
    bit [15:0]      sine_q15[0:90];
    rpa_pkg::t_axis axis;
    logic [15:0]    angle;
    rotated_point_t awaited_points[$];
    int             mismatches;

    function new();
        axis       = rpa_pkg::AXIS_X;
        angle      = '0;
        mismatches = 0;
        fill_sine_table();
    endfunction

    // quarter-wave sine from an integer taylor series in q31, then q30, then q15
    function void fill_sine_table();
        bit [63:0] step;
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] d;
        bit [63:0] q30;
        bit [63:0] m;
        longint    acc;
        step = 64'h3243F6A8885A308D / 64'd180;
        for (int k = 0; k <= 90; k++) begin
            x   = (step * 64'(k) + (64'd1 << 28)) >> 29;
            x2  = (x * x + (64'd1 << 30)) >> 31;
            acc = longint'(x);
            t   = x;
            for (int n = 1; n <= 13; n++) begin
                d = 64'(2 * n) * 64'(2 * n + 1);
                t = (t * x2 + (64'd1 << 30)) >> 31;
                t = (t + d / 2) / d;
                if (n % 2 == 1) begin
                    acc = acc - longint'(t);
                end else begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            q30 = (unsigned'(acc) + 64'd1) >> 1;
            if (q30 > (64'd1 << 30)) begin
                q30 = 64'd1 << 30;
            end
            m = (q30 + (64'd1 << 14)) >> 15;
            sine_q15[k] = m[15:0];
        end
        sine_q15[90] = 16'h8000;
    endfunction

    function longint coef(int unsigned idx, bit neg);
        return neg ? -longint'(sine_q15[idx]) : longint'(sine_q15[idx]);
    endfunction

    // product rounded half up to q16.16 (floor after adding half an lsb)
    function longint scaled_term(rpa_pkg::t_coord coord, longint k);
        longint v;
        v = longint'(coord) * k + 64'sd16384;
        return v >>> 15;
    endfunction

    function rpa_pkg::t_coord clamp32(longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return rpa_pkg::t_coord'(v);
    endfunction

    function rotated_point_t rotate_point(point_item_t p);
        int unsigned    a;
        int unsigned    quad;
        int unsigned    r;
        longint         c;
        longint         s;
        bit             flag;
        rotated_point_t o;
        a    = angle % 360;
        quad = a / 90;
        r    = a % 90;
        case (quad)
            0: begin
                s = coef(r, 1'b0);
                c = coef(90 - r, 1'b0);
            end
            1: begin
                s = coef(90 - r, 1'b0);
                c = coef(r, 1'b1);
            end
            2: begin
                s = coef(r, 1'b1);
                c = coef(90 - r, 1'b1);
            end
            default: begin
                s = coef(90 - r, 1'b1);
                c = coef(r, 1'b0);
            end
        endcase
        flag = 1'b0;
        o.x  = p.x;
        o.y  = p.y;
        o.z  = p.z;
        case (axis)
            rpa_pkg::AXIS_X: begin
                o.y = clamp32(scaled_term(p.y, c) + scaled_term(p.z, -s), flag);
                o.z = clamp32(scaled_term(p.y, s) + scaled_term(p.z, c), flag);
            end
            rpa_pkg::AXIS_Y: begin
                o.x = clamp32(scaled_term(p.x, c) + scaled_term(p.z, s), flag);
                o.z = clamp32(scaled_term(p.x, -s) + scaled_term(p.z, c), flag);
            end
            rpa_pkg::AXIS_Z: begin
                o.x = clamp32(scaled_term(p.x, c) + scaled_term(p.y, -s), flag);
                o.y = clamp32(scaled_term(p.x, s) + scaled_term(p.y, c), flag);
            end
            default: ;
        endcase
        o.saturated = flag;
        o.last      = p.last;
        return o;
    endfunction

    function void write_reg(logic [rpa_pkg::CFG_IDX_W-1:0] idx,
                            logic [rpa_pkg::CFG_DATA_W-1:0] data);
        if (idx == rpa_pkg::CFG_AXIS) begin
            axis = rpa_pkg::t_axis'(data[1:0]);
        end else if (idx == rpa_pkg::CFG_ANGLE) begin
            angle = data;
        end
    endfunction

    function void note_point(point_item_t p);
        awaited_points.push_back(rotate_point(p));
    endfunction

    function int pending();
        return awaited_points.size();
    endfunction

    function void check_point(rotated_point_t got);
        rotated_point_t want;
        bit             bad;
        if (awaited_points.size() == 0) begin
            $error("unexpected rotated point x_out=%0d y_out=%0d z_out=%0d",
                   got.x, got.y, got.z);
            mismatches++;
            return;
        end
        want = awaited_points.pop_front();
        bad  = 1'b0;
        if (got.x !== want.x) begin
            $error("x_out: expected %0d, got %0d", want.x, got.x);
            bad = 1'b1;
        end
        if (got.y !== want.y) begin
            $error("y_out: expected %0d, got %0d", want.y, got.y);
            bad = 1'b1;
        end
        if (got.z !== want.z) begin
            $error("z_out: expected %0d, got %0d", want.z, got.z);
            bad = 1'b1;
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
            bad = 1'b1;
        end
        if (got.last !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, got.last);
            bad = 1'b1;
        end
        if (bad) begin
            mismatches++;
        end
    endfunction
endclass

module tb_rotate_point_about_axis_top;
    import rpa_pkg::*;

    localparam int     CYCLE_LIMIT        = 200000;
    // pipeline is three deep; extra cycles after the last result catch stray strobes
    localparam int     SETTLE_CYCLES      = 8;
    localparam int     POINTS_PER_SETTING = 100;
    localparam t_coord COORD_MIN          = 32'sh80000000;
    localparam t_coord COORD_MAX          = 32'sh7FFFFFFF;

    // every input known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_AXIS;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    i_x_in      = '0;
    logic [COORD_W-1:0]    i_y_in      = '0;
    logic [COORD_W-1:0]    i_z_in      = '0;
    logic                  i_last_in   = 1'b0;
    logic                  o_valid;
    logic [COORD_W-1:0]    o_x_out;
    logic [COORD_W-1:0]    o_y_out;
    logic [COORD_W-1:0]    o_z_out;
    logic                  o_saturated;
    logic                  o_last_out;

    rotation_scoreboard rotation_sb = new();
    point_item_t        taken_point;
    rotated_point_t     seen_point;
    int unsigned        cycle_count;

    rotate_point_about_axis_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_z_in      (i_z_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out),
        .o_saturated (o_saturated),
        .o_last_out  (o_last_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // monitor: everything sampled at the edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // register writes never overlap an item, so order here is free
            if (i_cfg_we) begin
                rotation_sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (start && !busy) begin
                taken_point.x    = i_x_in;
                taken_point.y    = i_y_in;
                taken_point.z    = i_z_in;
                taken_point.last = i_last_in;
                rotation_sb.note_point(taken_point);
            end
            // results cannot be held off: every strobe is taken here
            if (o_valid) begin
                seen_point.x         = o_x_out;
                seen_point.y         = o_y_out;
                seen_point.z         = o_z_out;
                seen_point.saturated = o_saturated;
                seen_point.last      = o_last_out;
                rotation_sb.check_point(seen_point);
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic point_item_t point_of(t_coord x, t_coord y, t_coord z, logic last);
        point_item_t p;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        return p;
    endfunction

    function automatic t_coord random_coord();
        int tie;
        tie = int'(2 * $urandom_range(0, 1023) + 1) <<< 14;
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            // tiny values around zero
            2: return t_coord'(int'($urandom_range(0, 4095)) - 2048);
            // odd multiples of half a coefficient lsb: products land on ties
            3: return $urandom_range(0, 1) ? t_coord'(tie) : t_coord'(-tie);
            // near full scale, so that sums overflow
            4: return t_coord'({2'b01, 30'($urandom)});
            5: return t_coord'({2'b10, 30'($urandom)});
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 4))
            // exact quarter turns
            0: return 16'(90 * $urandom_range(0, 3));
            1: return 16'($urandom_range(0, 65535));
            // top of the register, or whole turns that wrap to zero
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'(360 * $urandom_range(1, 182));
            default: return 16'($urandom_range(0, 359));
        endcase
    endfunction

    function automatic point_item_t random_point();
        point_item_t p;
        p.x    = random_coord();
        p.y    = random_coord();
        p.z    = random_coord();
        p.last = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    // offer one item, idling first at the given rate, and hold it until taken
    task automatic send_point(point_item_t p, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_x_in    <= p.x;
        i_y_in    <= p.y;
        i_z_in    <= p.z;
        i_last_in <= p.last;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result, then let the pipe empty
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (rotation_sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // reprogram only with the block idle; both registers on back-to-back edges
    task automatic retune(t_axis axis, logic [15:0] angle);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AXIS;
        i_cfg_data  <= CFG_DATA_W'(axis);
        @(posedge i_clk);
        i_cfg_index <= CFG_ANGLE;
        i_cfg_data  <= angle;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(int idle_pct, int count);
        for (int i = 0; i < count; i++) begin
            if (i % POINTS_PER_SETTING == 0) begin
                retune(t_axis'($urandom_range(0, 2)), random_angle());
            end
            send_point(random_point(), idle_pct);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity rotation, extremes pass through untouched
        retune(AXIS_X, 16'd0);
        send_point(point_of(0, 0, 0, 1'b0), 0);
        send_point(point_of(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1), 0);

        // 45 degrees about z: full-scale inputs overflow both ways
        retune(AXIS_Z, 16'd45);
        send_point(point_of(COORD_MAX, COORD_MIN, 7, 1'b0), 0);
        send_point(point_of(COORD_MIN, COORD_MAX, -7, 1'b1), 0);
        send_point(point_of(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0), 0);

        // exact quarter turn about y; negating the minimum clamps
        retune(AXIS_Y, 16'd90);
        send_point(point_of(1, 2, 3, 1'b0), 0);
        send_point(point_of(COORD_MIN, 0, COORD_MIN, 1'b1), 0);

        // half turn about x
        retune(AXIS_X, 16'd180);
        send_point(point_of(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0), 0);
        send_point(point_of(COORD_MAX, -1, 1, 1'b1), 0);

        // three quarter turn about z
        retune(AXIS_Z, 16'd270);
        send_point(point_of(32'sd16384, -32'sd16384, 0, 1'b0), 0);
        send_point(point_of(COORD_MIN, COORD_MAX, 0, 1'b1), 0);

        // largest register value wraps to 15 degrees; rounding ties
        retune(AXIS_X, 16'hFFFF);
        send_point(point_of(32'sd16384, 32'sd16384, -32'sd16384, 1'b0), 0);
        send_point(point_of(32'sd49152, -32'sd114688, 5, 1'b1), 0);

        // just below and exactly one full turn
        retune(AXIS_Y, 16'd359);
        send_point(point_of(COORD_MAX, 3, COORD_MAX, 1'b0), 0);
        retune(AXIS_Z, 16'd360);
        send_point(point_of(COORD_MIN, COORD_MIN, 0, 1'b1), 0);

        // unused axis code leaves the point as it is
        retune(AXIS_NONE, 16'd123);
        send_point(point_of(COORD_MAX, COORD_MIN, -1, 1'b1), 0);

        // random part: sparse gaps, heavy gaps, then back to back
        run_random(29, 667);
        run_random(49, 667);
        run_random(0, 666);

        settle();
        if (rotation_sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
